FILE: rtl/core/wem_pkg.sv
// Shared types, constants and helpers for the windowed envelope min/max block.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps
`default_nettype none

package wem_pkg;

  localparam int SAMPLE_W = 16;
  localparam int POS_W    = 12;
  localparam int LEN_W    = 13;
  localparam int ENERGY_W = 17;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 2;

  localparam int MAX_WINDOW_DEF = 4096;

  localparam logic [LEN_W-1:0]    WINDOW_LENGTH_RST = LEN_W'(1380);
  localparam logic [ADDR_W-1:0]   ADDR_WINDOW_LENGTH = '0;

  localparam logic signed [SAMPLE_W-1:0] INIT_MAX = -16'sd32766;
  localparam logic signed [SAMPLE_W-1:0] INIT_MIN = 16'sd32766;

  // One window summary
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] upper_value;
    logic                       upper_found;
    logic [POS_W-1:0]           upper_pos;
    logic signed [SAMPLE_W-1:0] lower_value;
    logic                       lower_found;
    logic [POS_W-1:0]           lower_pos;
    logic [ENERGY_W-1:0]        energy;
  } result_t;

  // Magnitude of a signed sample, one bit wider so that -32768 fits
  function automatic logic [SAMPLE_W:0] abs_sample(input logic signed [SAMPLE_W-1:0] v);
    logic signed [SAMPLE_W:0] ext;
    ext = {v[SAMPLE_W-1], v};
    return v[SAMPLE_W-1] ? (SAMPLE_W + 1)'(-ext) : (SAMPLE_W + 1)'(ext);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/wem_cfg_regs.sv
// Configuration register bank: window length over an APB-style port.
// Depends on wem_pkg; produces the clamped effective window length.
`timescale 1ns / 1ps
`default_nettype none

module wem_cfg_regs (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire [wem_pkg::ADDR_W-1:0]      paddr,
  input  wire [wem_pkg::DATA_W-1:0]      pwdata,
  output logic [wem_pkg::DATA_W-1:0]     prdata,
  output logic                           pready,
  output logic [wem_pkg::LEN_W-1:0]      eff_len
);

  logic [wem_pkg::LEN_W-1:0] window_length_r;
  logic [wem_pkg::LEN_W-1:0] window_length_nxt;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == wem_pkg::ADDR_WINDOW_LENGTH);

  // Take a new length on the access phase of a write
  always_comb begin
    window_length_nxt = window_length_r;
    if (wr_en) begin
      window_length_nxt = pwdata[wem_pkg::LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= wem_pkg::WINDOW_LENGTH_RST;
    end else begin
      window_length_r <= window_length_nxt;
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (paddr == wem_pkg::ADDR_WINDOW_LENGTH) begin
      prdata = wem_pkg::DATA_W'(window_length_r);
    end
  end

  // Zero acts as one, anything above the maximum window as the maximum
  always_comb begin
    if (window_length_r == '0) begin
      eff_len = wem_pkg::LEN_W'(1);
    end else if (32'(window_length_r) > 32'(wem_pkg::MAX_WINDOW_DEF)) begin
      eff_len = wem_pkg::LEN_W'(wem_pkg::MAX_WINDOW_DEF);
    end else begin
      eff_len = window_length_r;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/wem_tracker.sv
// Running window state: max/min with first positions, window count, summary.
// Depends on wem_pkg; stepped once per word leaving the input register.
`timescale 1ns / 1ps
`default_nettype none

module wem_tracker (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  step,
  input  wire signed [wem_pkg::SAMPLE_W-1:0]   sample,
  input  wire                                  last_sample,
  input  wire [wem_pkg::LEN_W-1:0]             eff_len,
  output logic                                 emit,
  output wem_pkg::result_t                     result
);

  logic [wem_pkg::POS_W-1:0]          pos_r, pos_nxt;
  logic signed [wem_pkg::SAMPLE_W-1:0] max_r, max_nxt;
  logic [wem_pkg::POS_W-1:0]          max_pos_r, max_pos_nxt;
  logic                               max_found_r, max_found_nxt;
  logic signed [wem_pkg::SAMPLE_W-1:0] min_r, min_nxt;
  logic [wem_pkg::POS_W-1:0]          min_pos_r, min_pos_nxt;
  logic                               min_found_r, min_found_nxt;

  logic                               upd_max, upd_min;
  logic signed [wem_pkg::SAMPLE_W-1:0] cur_max, cur_min;
  logic [wem_pkg::POS_W-1:0]          cur_max_pos, cur_min_pos;
  logic                               cur_max_found, cur_min_found;
  logic [wem_pkg::LEN_W-1:0]          count;
  logic                               done;
  logic [wem_pkg::SAMPLE_W+1:0]       energy_sum;

  // Strict compares keep the first occurrence on ties
  assign upd_max       = sample > max_r;
  assign upd_min       = sample < min_r;
  assign cur_max       = upd_max ? sample : max_r;
  assign cur_min       = upd_min ? sample : min_r;
  assign cur_max_pos   = upd_max ? pos_r : max_pos_r;
  assign cur_min_pos   = upd_min ? pos_r : min_pos_r;
  assign cur_max_found = upd_max | max_found_r;
  assign cur_min_found = upd_min | min_found_r;

  assign count = {1'b0, pos_r} + wem_pkg::LEN_W'(1);
  assign done  = count >= eff_len;
  assign emit  = done && !last_sample;

  assign energy_sum = (wem_pkg::SAMPLE_W + 2)'(wem_pkg::abs_sample(cur_max))
                    + (wem_pkg::SAMPLE_W + 2)'(wem_pkg::abs_sample(cur_min));

  // Summary of the window closing on this word
  always_comb begin
    result.upper_value = cur_max;
    result.upper_found = cur_max_found;
    result.upper_pos   = cur_max_found ? cur_max_pos : '0;
    result.lower_value = cur_min;
    result.lower_found = cur_min_found;
    result.lower_pos   = cur_min_found ? cur_min_pos : '0;
    result.energy      = energy_sum[wem_pkg::ENERGY_W-1:0];
  end

  // Advance, or restart on a full window or the end of a recording
  always_comb begin
    pos_nxt       = pos_r;
    max_nxt       = max_r;
    max_pos_nxt   = max_pos_r;
    max_found_nxt = max_found_r;
    min_nxt       = min_r;
    min_pos_nxt   = min_pos_r;
    min_found_nxt = min_found_r;
    if (step) begin
      if (done || last_sample) begin
        pos_nxt       = '0;
        max_nxt       = wem_pkg::INIT_MAX;
        max_pos_nxt   = '0;
        max_found_nxt = 1'b0;
        min_nxt       = wem_pkg::INIT_MIN;
        min_pos_nxt   = '0;
        min_found_nxt = 1'b0;
      end else begin
        pos_nxt       = count[wem_pkg::POS_W-1:0];
        max_nxt       = cur_max;
        max_pos_nxt   = cur_max_pos;
        max_found_nxt = cur_max_found;
        min_nxt       = cur_min;
        min_pos_nxt   = cur_min_pos;
        min_found_nxt = cur_min_found;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      max_r       <= wem_pkg::INIT_MAX;
      max_pos_r   <= '0;
      max_found_r <= 1'b0;
      min_r       <= wem_pkg::INIT_MIN;
      min_pos_r   <= '0;
      min_found_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      max_r       <= max_nxt;
      max_pos_r   <= max_pos_nxt;
      max_found_r <= max_found_nxt;
      min_r       <= min_nxt;
      min_pos_r   <= min_pos_nxt;
      min_found_r <= min_found_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/windowed_envelope_min_max.sv
// Windowed envelope min/max detector, top level.
// Depends on wem_pkg, wem_cfg_regs and wem_tracker.
//
// Splits a stream of signed 16-bit samples into windows of window_length
// samples and, for each complete window, delivers one word with the highest
// and lowest sample, their first positions, found flags and energy
// |max|+|min|. A window closing on a sample marked last_sample is dropped,
// as is a trailing partial window; the next sample starts a fresh recording.
// One sample is accepted every clock cycle while in_stall is low; a result
// is loaded into the result register when its closing sample moves on from
// the input register (the input register feeds the compare/update into the
// result register). The input stalls only while the input register holds a
// closing sample and the result register still holds a word that has not
// been taken.
`timescale 1ns / 1ps
`default_nettype none

module windowed_envelope_min_max (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire signed [wem_pkg::SAMPLE_W-1:0]   in_sample,
  input  wire                                  in_last_sample,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic signed [wem_pkg::SAMPLE_W-1:0]  out_upper_value,
  output logic                                 out_upper_found,
  output logic [wem_pkg::POS_W-1:0]            out_upper_pos,
  output logic signed [wem_pkg::SAMPLE_W-1:0]  out_lower_value,
  output logic                                 out_lower_found,
  output logic [wem_pkg::POS_W-1:0]            out_lower_pos,
  output logic [wem_pkg::ENERGY_W-1:0]         out_energy,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire [wem_pkg::ADDR_W-1:0]            paddr,
  input  wire [wem_pkg::DATA_W-1:0]            pwdata,
  output logic [wem_pkg::DATA_W-1:0]           prdata,
  output logic                                 pready
);

  logic [wem_pkg::LEN_W-1:0]           eff_len;
  logic                                s1_valid_r, s1_valid_nxt;
  logic signed [wem_pkg::SAMPLE_W-1:0] s1_sample_r;
  logic                                s1_last_r;
  logic                                emit;
  wem_pkg::result_t                    result;
  logic                                out_free;
  logic                                adv;
  logic                                in_take;
  logic                                out_valid_r, out_valid_nxt;
  wem_pkg::result_t                    out_word_r;

  wem_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .eff_len (eff_len)
  );

  wem_tracker u_tracker (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (adv),
    .sample      (s1_sample_r),
    .last_sample (s1_last_r),
    .eff_len     (eff_len),
    .emit        (emit),
    .result      (result)
  );

  // The held word moves on unless it has a result and the output is full
  assign out_free = !out_valid_r || !out_stall;
  assign adv      = s1_valid_r && (!emit || out_free);
  assign in_stall = s1_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sample_r <= in_sample;
      s1_last_r   <= in_last_sample;
    end
  end

  // Result register: load a summary, drop it once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv && emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_word_r <= result;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_upper_value = out_word_r.upper_value;
  assign out_upper_found = out_word_r.upper_found;
  assign out_upper_pos   = out_word_r.upper_pos;
  assign out_lower_value = out_word_r.lower_value;
  assign out_lower_found = out_word_r.lower_found;
  assign out_lower_pos   = out_word_r.lower_pos;
  assign out_energy      = out_word_r.energy;

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for windowed_envelope_min_max: directed and random samples,
// window length changes over the APB port, output stalls and a long output hold-off.
// Depends on wem_pkg and the RTL of windowed_envelope_min_max.
`timescale 1ns / 1ps

// Tracks window state alongside the block and holds the summaries still to come out
class envelope_scoreboard;
  logic [wem_pkg::LEN_W-1:0]           win_len;
  logic [wem_pkg::POS_W-1:0]           pos_count;
  logic signed [wem_pkg::SAMPLE_W-1:0] run_max;
  logic signed [wem_pkg::SAMPLE_W-1:0] run_min;
  logic [wem_pkg::POS_W-1:0]           max_pos;
  logic [wem_pkg::POS_W-1:0]           min_pos;
  logic                                max_found;
  logic                                min_found;
  wem_pkg::result_t                    pending_windows[$];
  int                                  fails;

  function new();
    win_len = wem_pkg::WINDOW_LENGTH_RST;
    fails = 0;
    clear_window();
  endfunction

  function void clear_window();
    pos_count = '0;
    run_max = wem_pkg::INIT_MAX;
    run_min = wem_pkg::INIT_MIN;
    max_pos = '0;
    min_pos = '0;
    max_found = 1'b0;
    min_found = 1'b0;
  endfunction

  // Fold one accepted sample into the window; queue a summary when it closes
  function void note_sample(logic signed [wem_pkg::SAMPLE_W-1:0] s, logic lst);
    int eff;
    int count;
    int mag_max;
    int mag_min;
    wem_pkg::result_t r;
    if (s > run_max) begin
      run_max = s;
      max_pos = pos_count;
      max_found = 1'b1;
    end
    if (s < run_min) begin
      run_min = s;
      min_pos = pos_count;
      min_found = 1'b1;
    end
    // zero behaves as one, anything past the maximum is clamped
    if (win_len == 0) eff = 1;
    else if (int'(win_len) > wem_pkg::MAX_WINDOW_DEF) eff = wem_pkg::MAX_WINDOW_DEF;
    else eff = int'(win_len);
    count = int'(pos_count) + 1;
    if (count >= eff) begin
      if (!lst) begin
        mag_max = (run_max < 0) ? -int'(run_max) : int'(run_max);
        mag_min = (run_min < 0) ? -int'(run_min) : int'(run_min);
        r.upper_value = run_max;
        r.upper_found = max_found;
        r.upper_pos   = max_found ? max_pos : '0;
        r.lower_value = run_min;
        r.lower_found = min_found;
        r.lower_pos   = min_found ? min_pos : '0;
        r.energy      = wem_pkg::ENERGY_W'(mag_max + mag_min);
        pending_windows = {pending_windows, r};
      end
      clear_window();
    end else begin
      pos_count = count[wem_pkg::POS_W-1:0];
    end
    // the last sample always ends the recording
    if (lst) clear_window();
  endfunction

  function void compare_field(string name, integer want, integer got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  // Compare one delivered summary against the oldest one queued
  function void check_window(wem_pkg::result_t got);
    wem_pkg::result_t want;
    if (pending_windows.size() == 0) begin
      $error("window summary delivered with none outstanding");
      fails++;
      return;
    end
    want = pending_windows.pop_front();
    compare_field("upper_value", want.upper_value, got.upper_value);
    compare_field("upper_found", want.upper_found, got.upper_found);
    compare_field("upper_pos", want.upper_pos, got.upper_pos);
    compare_field("lower_value", want.lower_value, got.lower_value);
    compare_field("lower_found", want.lower_found, got.lower_found);
    compare_field("lower_pos", want.lower_pos, got.lower_pos);
    compare_field("energy", want.energy, got.energy);
  endfunction
endclass

module testbench;
  import wem_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS = 1300;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic in_last_sample;
  logic out_valid;
  logic out_stall;
  logic signed [SAMPLE_W-1:0] out_upper_value;
  logic out_upper_found;
  logic [POS_W-1:0] out_upper_pos;
  logic signed [SAMPLE_W-1:0] out_lower_value;
  logic out_lower_found;
  logic [POS_W-1:0] out_lower_pos;
  logic [ENERGY_W-1:0] out_energy;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  envelope_scoreboard sb;
  bit hold_req = 1'b0;
  int burst_left = 0;
  int cycles = 0;

  windowed_envelope_min_max dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sample(in_sample),
    .in_last_sample(in_last_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_upper_value(out_upper_value),
    .out_upper_found(out_upper_found),
    .out_upper_pos(out_upper_pos),
    .out_lower_value(out_lower_value),
    .out_lower_found(out_lower_found),
    .out_lower_pos(out_lower_pos),
    .out_energy(out_energy),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Stall the output on a changing duty, or hold it off for a long stretch on request
  initial begin
    int pct;
    int span;
    out_stall = 1'b0;
    pct = 0;
    span = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (span == 0) begin
          span = $urandom_range(20, 100);
          case ($urandom_range(0, 4))
            0, 1: pct = 0;
            2: pct = 20;
            3: pct = 50;
            default: pct = 85;
          endcase
        end
        span--;
        out_stall <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  // Check every word taken from the output
  always @(posedge clk) begin : watch_results
    result_t seen;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      seen.upper_value = out_upper_value;
      seen.upper_found = out_upper_found;
      seen.upper_pos   = out_upper_pos;
      seen.lower_value = out_lower_value;
      seen.lower_found = out_lower_found;
      seen.lower_pos   = out_lower_pos;
      seen.energy      = out_energy;
      sb.check_window(seen);
    end
  end

  // Offer one sample, opening a random gap between bursts, and hold it until taken
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic lst);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_last_sample <= lst;
    do @(posedge clk); while (in_stall);
    sb.note_sample(s, lst);
    burst_left--;
  endtask

  // Drop valid and wait until every summary has come out and the pipeline is empty
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_windows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ADDR_WINDOW_LENGTH;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Write the window length, then read it back
  task automatic set_window_length(input logic [LEN_W-1:0] len);
    logic [DATA_W-1:0] rd;
    drain();
    apb_access(1'b1, DATA_W'(len), rd);
    sb.win_len = len;
    apb_access(1'b0, '0, rd);
    if (rd !== DATA_W'(len)) begin
      $error("window_length readback: expected %0d, got %0d", len, rd);
      sb.fails++;
    end
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 5))
          0: return -16'sd32768;
          1: return -16'sd32767;
          2: return -16'sd32766;
          3: return 16'sd32766;
          4: return 16'sd32767;
          default: return 16'sd0;
        endcase
      end
      // narrow range so that ties are common
      1: return SAMPLE_W'($signed($urandom_range(0, 6)) - 3);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    int sent;
    int n;
    int last_den;
    int len;
    bit hold_done;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    in_last_sample = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset length: a short recording is dropped as a partial window
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd100, 1'b0);
    send_sample(16'sd5, 1'b1);

    // full-scale extremes, ties keep the first position
    set_window_length(13'd4);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    // nothing beats the starting maximum
    send_sample(-16'sd32768, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(-16'sd32767, 1'b0);
    send_sample(-16'sd32766, 1'b0);
    // nothing goes below the starting minimum
    send_sample(16'sd32766, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(16'sd32766, 1'b0);
    send_sample(16'sd32767, 1'b0);
    // window closing on the last sample is dropped
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd2, 1'b0);
    send_sample(16'sd3, 1'b0);
    send_sample(16'sd4, 1'b1);
    // partial window at the end of a recording
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd6, 1'b1);
    // shorten the window part way through
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd1, 1'b0);
    set_window_length(13'd2);
    send_sample(16'sd7, 1'b0);

    // random phases, mostly short windows
    sent = 0;
    hold_done = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: len = 0;
        1: len = 1;
        2: len = 2;
        8: len = $urandom_range(25, 200);
        9: len = $urandom_range(2, 8);
        default: len = $urandom_range(3, 24);
      endcase
      if (!hold_done && sent > 300) len = 1;
      set_window_length(LEN_W'(len));
      case ($urandom_range(0, 3))
        0: last_den = 0;
        1: last_den = 8;
        2: last_den = 30;
        default: last_den = 100;
      endcase
      n = $urandom_range(40, 150);
      // back-pressure the output until the block stalls its input
      if (!hold_done && len == 1 && sent > 300) begin
        hold_done = 1'b1;
        hold_req = 1'b1;
      end
      repeat (n) begin
        send_sample(pick_sample(), (last_den != 0) && ($urandom_range(1, last_den) == 1));
        sent++;
      end
    end

    // over-range length acts as the widest window, then the maximum with a partial window
    set_window_length(13'd8191);
    repeat (20) send_sample(pick_sample(), 1'b0);
    send_sample(pick_sample(), 1'b1);
    set_window_length(13'd4096);
    repeat (9) send_sample(pick_sample(), 1'b0);
    send_sample(pick_sample(), 1'b1);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.fails == 0 && sb.pending_windows.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
